// ===== rtl/dsel_pkg.sv =====
package dsel_pkg;

  // list geometry; the 7-bit entry_count field holds a full list of 64
  localparam int unsigned ListDepth = 64;
  localparam int unsigned AddrW     = $clog2(ListDepth);
  localparam int unsigned CountW    = 7;
  localparam int unsigned EntryW    = 39;

  // request codes; bit 1 selects a dump, so code three dumps as well
  localparam logic [1:0]  ReqInsert  = 2'd0;
  localparam logic [1:0]  ReqAppend  = 2'd1;
  localparam int unsigned ReqDumpBit = 1;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StFull     = 2'd1,
    StEntry    = 2'd2,
    StEmpty    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND_RD,
    S_FIND_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_DUMP_RD,
    S_DUMP_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] event_tag;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [13:0] entry_year;
    logic [3:0]  entry_month;
    logic [4:0]  entry_day;
    logic [15:0] entry_tag;
    logic [6:0]  entry_count;
    logic        last;
  } res_t;

  // one stored list entry
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] tag;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    rd_en;
    logic    shift;
    logic    place;
    logic    place_tail;
    logic    set_pos;
    logic    idx_tail;
    logic    idx_dec;
    logic    idx_inc;
    logic    emit;
    logic    emit_entry;
    logic    emit_last;
    status_e emit_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_dump;
    logic is_append;
    logic full;
    logic empty;
    logic greater;
    logic idx_last;
    logic idx_at_pos;
  } dp_status_t;

endpackage

// ===== rtl/dsel_ram.sv =====
module dsel_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dsel_ctrl.sv =====
module dsel_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  dsel_pkg::dp_status_t stat_i,
  output dsel_pkg::cmd_t      cmd_o,
  output logic                busy_o
);

  dsel_pkg::ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsel_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dsel_pkg::S_IDLE: begin
        if (start_i) state_d = dsel_pkg::S_DECODE;
      end
      dsel_pkg::S_DECODE: begin
        if (stat_i.is_dump) begin
          state_d = stat_i.empty ? dsel_pkg::S_IDLE : dsel_pkg::S_DUMP_RD;
        end else if (stat_i.full || stat_i.is_append || stat_i.empty) begin
          state_d = dsel_pkg::S_IDLE;
        end else begin
          state_d = dsel_pkg::S_FIND_RD;
        end
      end
      dsel_pkg::S_FIND_RD: begin
        state_d = dsel_pkg::S_FIND_CMP;
      end
      dsel_pkg::S_FIND_CMP: begin
        if (stat_i.greater) begin
          state_d = dsel_pkg::S_SHIFT_RD;
        end else if (stat_i.idx_last) begin
          state_d = dsel_pkg::S_IDLE;
        end else begin
          state_d = dsel_pkg::S_FIND_RD;
        end
      end
      dsel_pkg::S_SHIFT_RD: begin
        state_d = dsel_pkg::S_SHIFT_WR;
      end
      dsel_pkg::S_SHIFT_WR: begin
        state_d = stat_i.idx_at_pos ? dsel_pkg::S_PLACE : dsel_pkg::S_SHIFT_RD;
      end
      dsel_pkg::S_PLACE: begin
        state_d = dsel_pkg::S_IDLE;
      end
      dsel_pkg::S_DUMP_RD: begin
        state_d = dsel_pkg::S_DUMP_OUT;
      end
      dsel_pkg::S_DUMP_OUT: begin
        state_d = stat_i.idx_last ? dsel_pkg::S_IDLE : dsel_pkg::S_DUMP_RD;
      end
      default: state_d = dsel_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o             = '0;
    cmd_o.emit_status = dsel_pkg::StInserted;
    case (state_q)
      dsel_pkg::S_IDLE: begin
        cmd_o.load = start_i;
      end
      dsel_pkg::S_DECODE: begin
        if (stat_i.is_dump) begin
          if (stat_i.empty) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_last   = 1'b1;
            cmd_o.emit_status = dsel_pkg::StEmpty;
          end
        end else if (stat_i.full) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = dsel_pkg::StFull;
        end else if (stat_i.is_append || stat_i.empty) begin
          // append, or first entry: goes right after the tail
          cmd_o.place      = 1'b1;
          cmd_o.place_tail = 1'b1;
          cmd_o.emit       = 1'b1;
          cmd_o.emit_last  = 1'b1;
        end
      end
      dsel_pkg::S_FIND_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      dsel_pkg::S_FIND_CMP: begin
        if (stat_i.greater) begin
          // first later date: new entry goes here, move the rest from the tail
          cmd_o.set_pos  = 1'b1;
          cmd_o.idx_tail = 1'b1;
        end else if (stat_i.idx_last) begin
          // no later date held: new entry goes after the tail
          cmd_o.place      = 1'b1;
          cmd_o.place_tail = 1'b1;
          cmd_o.emit       = 1'b1;
          cmd_o.emit_last  = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      dsel_pkg::S_SHIFT_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      dsel_pkg::S_SHIFT_WR: begin
        // move the read entry up one slot and keep walking down
        cmd_o.shift   = 1'b1;
        cmd_o.idx_dec = !stat_i.idx_at_pos;
      end
      dsel_pkg::S_PLACE: begin
        cmd_o.place     = 1'b1;
        cmd_o.emit      = 1'b1;
        cmd_o.emit_last = 1'b1;
      end
      dsel_pkg::S_DUMP_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      dsel_pkg::S_DUMP_OUT: begin
        cmd_o.emit        = 1'b1;
        cmd_o.emit_entry  = 1'b1;
        cmd_o.emit_last   = stat_i.idx_last;
        cmd_o.emit_status = dsel_pkg::StEntry;
        cmd_o.idx_inc     = !stat_i.idx_last;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != dsel_pkg::S_IDLE);

endmodule

// ===== rtl/dsel_dp.sv =====
module dsel_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dsel_pkg::req_t       req_i,
  input  dsel_pkg::cmd_t       cmd_i,
  output dsel_pkg::dp_status_t stat_o,
  output logic                 res_valid_o,
  output dsel_pkg::res_t       res_o
);

  localparam int unsigned AW = dsel_pkg::AddrW;
  localparam int unsigned CW = dsel_pkg::CountW;

  dsel_pkg::req_t   req_q;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    pos_q;
  logic [CW-1:0]    fill_q, fill_d;
  logic             res_valid_q;
  dsel_pkg::res_t   res_q, res_d;

  dsel_pkg::entry_t new_entry;
  dsel_pkg::entry_t rd_entry;
  logic [dsel_pkg::EntryW-1:0] ram_rdata;
  logic [dsel_pkg::EntryW-1:0] ram_wdata;
  logic [AW-1:0]    ram_waddr;
  logic             ram_we;

  assign new_entry.year  = req_q.year;
  assign new_entry.month = req_q.month;
  assign new_entry.day   = req_q.day;
  assign new_entry.tag   = req_q.event_tag;
  assign rd_entry        = dsel_pkg::entry_t'(ram_rdata);

  // write port: shift the read entry up a slot, or place the new entry
  assign ram_we    = cmd_i.shift | cmd_i.place;
  assign ram_waddr = cmd_i.shift      ? idx_q + AW'(1) :
                     cmd_i.place_tail ? fill_q[AW-1:0] : pos_q;
  assign ram_wdata = cmd_i.shift ? ram_rdata : new_entry;

  dsel_ram #(
    .Width (dsel_pkg::EntryW),
    .Depth (dsel_pkg::ListDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // walk index; dumps and date searches start at the head, moves at the tail
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.idx_tail) begin
      idx_d = fill_q[AW-1:0] - AW'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - AW'(1);
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end
  end

  assign fill_d = cmd_i.place ? fill_q + CW'(1) : fill_q;

  // result beat; count reflects the list after this item
  always_comb begin
    res_d             = '0;
    res_d.status      = cmd_i.emit_status;
    res_d.entry_count = fill_d;
    res_d.last        = cmd_i.emit_last;
    if (cmd_i.emit_entry) begin
      res_d.entry_year  = rd_entry.year;
      res_d.entry_month = rd_entry.month;
      res_d.entry_day   = rd_entry.day;
      res_d.entry_tag   = rd_entry.tag;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      res_valid_q <= cmd_i.emit;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.set_pos) begin
      pos_q <= idx_q;
    end
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  // status to the controller; plain (y, m, d) order matches the date key
  assign stat_o.is_dump    = req_q.req_type[dsel_pkg::ReqDumpBit];
  assign stat_o.is_append  = (req_q.req_type == dsel_pkg::ReqAppend);
  assign stat_o.full       = (fill_q == CW'(dsel_pkg::ListDepth));
  assign stat_o.empty      = (fill_q == '0);
  assign stat_o.greater    = {rd_entry.year, rd_entry.month, rd_entry.day} >
                             {new_entry.year, new_entry.month, new_entry.day};
  assign stat_o.idx_last   = (CW'(idx_q) == fill_q - CW'(1));
  assign stat_o.idx_at_pos = (idx_q == pos_q);

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/date_sorted_event_list_top.sv =====
// Bounded date-sorted event list, 64 entries, one item at a time.
// Append, full drop, empty dump and first entry: one beat, issued in decode.
// Sorted insert walks from the head to the first later date, then moves entries
// up from the tail and places the new one, or places it after the tail if none.
// A dump reads each entry from the head in turn and gives one beat for each.
// Next item taken while the last beat is shown; reset clears fill count and FSM.
module date_sorted_event_list_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  dsel_pkg::req_t req_i,
  output logic           res_valid_o,
  output dsel_pkg::res_t res_o
);

  dsel_pkg::cmd_t       cmd;
  dsel_pkg::dp_status_t stat;

  dsel_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  dsel_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// ===== tb/date_sorted_event_list_top_tb.sv =====
`timescale 1ns / 100ps

module date_sorted_event_list_top_tb;

  // dump codes; bit 1 selects the dump, so code three dumps too
  localparam logic [1:0]  ReqDump    = 2'd2;
  localparam logic [1:0]  ReqDumpAlt = 2'd3;

  // sender idle rates, percent of cycles
  localparam int unsigned IdleNone   = 0;
  localparam int unsigned IdleSender = 74;
  localparam int unsigned IdleBoth   = 38;

  localparam int unsigned TotalBeats  = 410;
  localparam int unsigned DrainCycles = 140;
  localparam int unsigned CycleLimit  = 400000;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  dsel_pkg::req_t req_i;
  logic           res_valid_o;
  dsel_pkg::res_t res_o;

  // mirror of the list contents
  dsel_pkg::entry_t dated_list [dsel_pkg::ListDepth];
  int unsigned      list_len;
  dsel_pkg::res_t   due_results [$];

  int unsigned err_cnt;
  int unsigned beats_sent;
  int unsigned cycle_cnt;
  int unsigned idle_pct;

  date_sorted_event_list_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // sort key; month and day never reach into the year digits
  function automatic int unsigned date_key(logic [13:0] y, logic [3:0] m, logic [4:0] d);
    return 32'(y) * 32'd10000 + 32'(m) * 32'd100 + 32'(d);
  endfunction

  function automatic dsel_pkg::res_t blank_result(dsel_pkg::status_e st, logic is_last);
    dsel_pkg::res_t r;
    r = '0;
    r.status      = st;
    r.entry_count = list_len[6:0];
    r.last        = is_last;
    return r;
  endfunction

  // update the mirror and queue the results this request causes
  function automatic void apply_request(dsel_pkg::req_t r);
    dsel_pkg::entry_t ne;
    int unsigned      pos;
    dsel_pkg::res_t   res;
    if (r.req_type[dsel_pkg::ReqDumpBit]) begin
      if (list_len == 0) begin
        due_results.push_back(blank_result(dsel_pkg::StEmpty, 1'b1));
      end else begin
        for (int i = 0; i < list_len; i++) begin
          res             = blank_result(dsel_pkg::StEntry, i == list_len - 1);
          res.entry_year  = dated_list[i].year;
          res.entry_month = dated_list[i].month;
          res.entry_day   = dated_list[i].day;
          res.entry_tag   = dated_list[i].tag;
          due_results.push_back(res);
        end
      end
      return;
    end
    ne.year  = r.year;
    ne.month = r.month;
    ne.day   = r.day;
    ne.tag   = r.event_tag;
    if (list_len >= dsel_pkg::ListDepth) begin
      due_results.push_back(blank_result(dsel_pkg::StFull, 1'b1));
      return;
    end
    pos = list_len;
    // sorted insert goes before the first strictly later date
    if (r.req_type == dsel_pkg::ReqInsert) begin
      for (int i = 0; i < list_len; i++) begin
        if (date_key(dated_list[i].year, dated_list[i].month, dated_list[i].day) >
            date_key(ne.year, ne.month, ne.day)) begin
          pos = i;
          break;
        end
      end
    end
    for (int i = int'(list_len); i > pos; i--) dated_list[i] = dated_list[i - 1];
    dated_list[pos] = ne;
    list_len++;
    due_results.push_back(blank_result(dsel_pkg::StInserted, 1'b1));
  endfunction

  function automatic dsel_pkg::req_t mk_req(logic [1:0] rt, logic [13:0] y, logic [3:0] m,
                                            logic [4:0] d, logic [15:0] t);
    dsel_pkg::req_t r;
    r.req_type  = rt;
    r.year      = y;
    r.month     = m;
    r.day       = d;
    r.event_tag = t;
    return r;
  endfunction

  // random request; dates often collide so equal-key ordering gets hit
  function automatic dsel_pkg::req_t rand_req(int unsigned dump_pct);
    dsel_pkg::req_t r;
    r.event_tag = 16'($urandom);
    if ($urandom_range(99) < dump_pct) begin
      r.req_type = $urandom_range(1) ? ReqDump : ReqDumpAlt;
    end else begin
      r.req_type = ($urandom_range(3) == 0) ? dsel_pkg::ReqAppend : dsel_pkg::ReqInsert;
    end
    case ($urandom_range(3))
      0: begin
        r.year  = 14'($urandom_range(16383));
        r.month = 4'($urandom_range(15));
        r.day   = 5'($urandom_range(31));
      end
      1: begin
        r.year  = 14'($urandom_range(2001, 1999));
        r.month = 4'($urandom_range(2, 1));
        r.day   = 5'($urandom_range(2, 1));
      end
      2: begin
        r.year  = 14'($urandom_range(9999));
        r.month = 4'($urandom_range(12, 1));
        r.day   = 5'($urandom_range(31, 1));
      end
      default: begin
        r.year  = $urandom_range(1) ? 14'h3FFF : 14'h0000;
        r.month = 4'($urandom_range(15));
        r.day   = 5'($urandom_range(31));
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned phase_idle();
    case ((beats_sent / 24) % 3)
      0:       return IdleNone;
      1:       return IdleSender;
      default: return IdleBoth;
    endcase
  endfunction

  task automatic report_err(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_err($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // one beat: optional idle, then hold start until accepted
  task automatic send_beat(input dsel_pkg::req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apply_request(r);
    beats_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // empty dumps, head and equal-date inserts, append, field extremes
  task automatic test_directed();
    idle_pct = IdleNone;
    send_beat(mk_req(ReqDump,             14'd0,     4'd0,  5'd0,     16'h0000));
    send_beat(mk_req(ReqDumpAlt,          14'h3FFF,  4'hF,  5'h1F,    16'hFFFF));
    send_beat(mk_req(dsel_pkg::ReqInsert, 14'd2000,  4'd6,  5'd15,    16'd1));
    send_beat(mk_req(dsel_pkg::ReqInsert, 14'd1999,  4'd12, 5'd31,    16'd2));
    send_beat(mk_req(dsel_pkg::ReqInsert, 14'd2000,  4'd6,  5'd15,    16'd3));
    send_beat(mk_req(dsel_pkg::ReqAppend, 14'd0,     4'd1,  5'd1,     16'd4));
    send_beat(mk_req(dsel_pkg::ReqInsert, 14'h3FFF,  4'hF,  5'h1F,    16'hFFFF));
    send_beat(mk_req(dsel_pkg::ReqInsert, 14'd0,     4'd0,  5'd0,     16'h0000));
    send_beat(mk_req(dsel_pkg::ReqInsert, 14'd2000,  4'd6,  5'd16,    16'd5));
    send_beat(mk_req(dsel_pkg::ReqInsert, 14'h2AAA,  4'hA,  5'h15,    16'hAAAA));
    send_beat(mk_req(dsel_pkg::ReqInsert, 14'h1555,  4'h5,  5'h0A,    16'h5555));
    send_beat(mk_req(ReqDumpAlt,          14'd0,     4'd0,  5'd0,     16'h0000));
    send_beat(mk_req(dsel_pkg::ReqAppend, 14'd9999,  4'd12, 5'd31,    16'h1234));
    send_beat(mk_req(dsel_pkg::ReqInsert, 14'd2000,  4'd6,  5'd15,    16'd6));
    send_beat(mk_req(ReqDump,             14'h3FFF,  4'hF,  5'h1F,    16'hFFFF));
  endtask

  // let everything drain, then a back-to-back burst from idle
  task automatic test_drain_then_burst();
    wait_drain();
    idle_pct = IdleNone;
    repeat (6) send_beat(rand_req(0));
    wait_drain();
    send_beat(mk_req(ReqDump, 14'd0, 4'd0, 5'd0, 16'd0));
  endtask

  // random inserts, appends and dumps until the list is full
  task automatic test_fill_random();
    while (list_len < dsel_pkg::ListDepth) begin
      idle_pct = phase_idle();
      send_beat(rand_req(20));
    end
  endtask

  // full list: every insert drops, dumps walk all 64 entries
  task automatic test_full_list();
    while (beats_sent < TotalBeats) begin
      idle_pct = phase_idle();
      send_beat(rand_req(40));
    end
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_results
    dsel_pkg::res_t want;
    if (rst_ni && res_valid_o) begin
      if (due_results.size() == 0) begin
        report_err($sformatf("unexpected result status %0d count %0d",
                             res_o.status, res_o.entry_count));
      end else begin
        want = due_results.pop_front();
        check_field("status",      16'(res_o.status),      16'(want.status));
        check_field("entry_year",  16'(res_o.entry_year),  16'(want.entry_year));
        check_field("entry_month", 16'(res_o.entry_month), 16'(want.entry_month));
        check_field("entry_day",   16'(res_o.entry_day),   16'(want.entry_day));
        check_field("entry_tag",   res_o.entry_tag,        want.entry_tag);
        check_field("entry_count", 16'(res_o.entry_count), 16'(want.entry_count));
        check_field("last",        16'(res_o.last),        16'(want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("date_sorted_event_list_top_tb: errors");
      $finish;
    end
  end

  initial begin
    start      = 1'b0;
    req_i      = '0;
    rst_ni     = 1'b0;
    list_len   = 0;
    err_cnt    = 0;
    beats_sent = 0;
    cycle_cnt  = 0;
    idle_pct   = IdleNone;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_drain_then_burst();
    test_fill_random();
    test_full_list();

    wait_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("date_sorted_event_list_top_tb: clean");
    end else begin
      $display("date_sorted_event_list_top_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dsel_pkg.sv
rtl/dsel_ram.sv
rtl/dsel_ctrl.sv
rtl/dsel_dp.sv
rtl/date_sorted_event_list_top.sv
tb/date_sorted_event_list_top_tb.sv
